// ===== hw/rtl/sws_pkg.sv =====
// Shared constants, codes and control/status types of the sliding window sender.
package sws_pkg;

  // Ring of payload slots and the largest number of packets a send round may emit.
  localparam int BUF_DEPTH = 16;
  localparam int MAX_OUT   = 16;
  localparam int SLOT_W    = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
  localparam int SUM_W     = SLOT_W + 1;
  localparam int NLANE     = (BUF_DEPTH < MAX_OUT) ? BUF_DEPTH : MAX_OUT;

  // Field widths.
  localparam int SEQ_W  = 16;
  localparam int BYTE_W = 8;
  localparam int WIN_W  = 5;
  localparam int CFG_W  = 16;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_MESSAGE_LENGTH = CFG_IDX_W'(1);

  localparam logic [WIN_W-1:0] WIN_RESET = WIN_W'(4);
  localparam logic [SEQ_W-1:0] TERM_SEQ  = 16'hFFFF;

  // Input command codes.
  localparam logic [1:0] CMD_LOAD = 2'd0;
  localparam logic [1:0] CMD_SEND = 2'd1;
  localparam logic [1:0] CMD_ACK  = 2'd2;

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_ACK  = 2'd1,
    KIND_TERM = 2'd2,
    KIND_LOAD = 2'd3
  } kind_t;

  typedef struct packed {
    logic  cap_item;
    logic  do_load;
    logic  ack_mark;
    logic  adv_step;
    logic  cap_elig;
    logic  scan_step;
    logic  ram_rd;
    logic  emit;
    kind_t emit_kind;
    logic  emit_acc;
    logic  emit_last;
  } sws_cmd_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       load_ok;
    logic       ack_valid;
    logic       base_done;
    logic       adv_more;
    logic       elig_any;
    logic       elig_cur;
    logic       elig_rest;
    logic       out_free;
  } sws_sts_t;

endpackage

// ===== hw/rtl/sliding_window_sender_top.sv =====
// Top level of the sliding window sender: ports, field packing and the two sub-blocks.
//
// Selective-repeat sender over a ring of BUF_DEPTH payload slots. Items arrive on the
// in_ stream, one command each: load a message byte, run a send round, or take an
// acknowledgement. Results leave on the out_ stream; out_tlast marks the final result
// of an item, and out_tuser gives its kind. The user must write window_size and
// message_length through cfg_ only while the block is idle; nothing enforces this.
//
// Items are handled one at a time; in_tready is high only while the controller waits
// for the next item. The result of a load, a refused acknowledgement or a terminate
// round is written to the output register from the decode state once that register is
// free. An accepted acknowledgement marks its slot, then moves the window base over the
// acknowledged slots one at a time (at most BUF_DEPTH) before its result is written. A
// send round captures the eligible window lanes and walks them in order, skipping the
// others; it sends at most min(BUF_DEPTH, 16) packets, each after a registered read of
// the payload ring. A round with no eligible lane writes no result.
//
// Reset clears the window state and the acknowledge map at once; there is no clearing
// pass. A stalled out_tready holds the result in the output register, and the block
// waits before writing the next one; a new item may be taken while the last result of
// the previous one is still waiting.
module sliding_window_sender_top import sws_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wen,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [31:0]          in_tdata,  // data_byte[7:0], ack_number[23:8], ack_ok[24]
  input  logic [1:0]           in_tuser,  // command[1:0]
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [47:0]          out_tdata, // seq_number[15:0], payload[23:16],
                                          // window_base[39:24], accepted[40]
  output logic [1:0]           out_tuser, // kind[1:0]
  output logic                 out_tlast
);

  sws_cmd_t          ctl;
  sws_sts_t          sts;
  kind_t             out_kind;
  logic [SEQ_W-1:0]  out_seq_number;
  logic [BYTE_W-1:0] out_payload;
  logic [SEQ_W-1:0]  out_window_base;
  logic              out_accepted;

  sws_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .sts      (sts),
    .ctl      (ctl)
  );

  sws_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wen        (cfg_wen),
    .cfg_idx        (cfg_idx),
    .cfg_wdata      (cfg_wdata),
    .item_command   (in_tuser),
    .item_data_byte (in_tdata[7:0]),
    .item_ack_number(in_tdata[23:8]),
    .item_ack_ok    (in_tdata[24]),
    .ctl            (ctl),
    .sts            (sts),
    .out_tready     (out_tready),
    .out_tvalid     (out_tvalid),
    .out_kind       (out_kind),
    .out_seq_number (out_seq_number),
    .out_payload    (out_payload),
    .out_window_base(out_window_base),
    .out_accepted   (out_accepted),
    .out_last       (out_tlast)
  );

  assign out_tdata = {7'd0, out_accepted, out_window_base, out_payload, out_seq_number};
  assign out_tuser = out_kind;

endmodule

// ===== hw/rtl/sws_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
module sws_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [$clog2(DEPTH)-1:0]  waddr,
  input  logic [WIDTH-1:0]          wdata,
  input  logic                      re,
  input  logic [$clog2(DEPTH)-1:0]  raddr,
  output logic [WIDTH-1:0]          rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/sws_ctrl.sv =====
// Controller state machine of the sliding window sender.
module sws_ctrl import sws_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  input  sws_sts_t sts,
  output sws_cmd_t ctl
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_ADVANCE,
    S_SCAN,
    S_FETCH
  } state_t;

  state_t state_r, state_nxt;
  logic   in_tready_r;

  always_comb begin
    state_nxt     = state_r;
    ctl.cap_item  = 1'b0;
    ctl.do_load   = 1'b0;
    ctl.ack_mark  = 1'b0;
    ctl.adv_step  = 1'b0;
    ctl.cap_elig  = 1'b0;
    ctl.scan_step = 1'b0;
    ctl.ram_rd    = 1'b0;
    ctl.emit      = 1'b0;
    ctl.emit_kind = KIND_DATA;
    ctl.emit_acc  = 1'b0;
    ctl.emit_last = 1'b1;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid && in_tready_r) begin
          ctl.cap_item = 1'b1;
          state_nxt    = S_DECODE;
        end
      end
      S_DECODE: begin
        case (sts.cmd)
          CMD_LOAD: begin
            if (sts.out_free) begin
              ctl.do_load   = sts.load_ok;
              ctl.emit      = 1'b1;
              ctl.emit_kind = KIND_LOAD;
              ctl.emit_acc  = sts.load_ok;
              state_nxt     = S_IDLE;
            end
          end
          CMD_SEND: begin
            if (sts.base_done) begin
              if (sts.out_free) begin
                ctl.emit      = 1'b1;
                ctl.emit_kind = KIND_TERM;
                state_nxt     = S_IDLE;
              end
            end else begin
              ctl.cap_elig = 1'b1;
              state_nxt    = S_SCAN;
            end
          end
          CMD_ACK: begin
            if (sts.ack_valid) begin
              ctl.ack_mark = 1'b1;
              state_nxt    = S_ADVANCE;
            end else if (sts.out_free) begin
              ctl.emit      = 1'b1;
              ctl.emit_kind = KIND_ACK;
              state_nxt     = S_IDLE;
            end
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
      end
      S_ADVANCE: begin
        // Move the base over acknowledged slots one at a time.
        if (sts.adv_more) begin
          ctl.adv_step = 1'b1;
        end else if (sts.out_free) begin
          ctl.emit      = 1'b1;
          ctl.emit_kind = KIND_ACK;
          ctl.emit_acc  = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_SCAN: begin
        if (!sts.elig_any) begin
          state_nxt = S_IDLE;
        end else if (sts.elig_cur) begin
          ctl.ram_rd = 1'b1;
          state_nxt  = S_FETCH;
        end else begin
          ctl.scan_step = 1'b1;
        end
      end
      S_FETCH: begin
        if (sts.out_free) begin
          ctl.emit      = 1'b1;
          ctl.emit_kind = KIND_DATA;
          ctl.emit_last = !sts.elig_rest;
          ctl.scan_step = 1'b1;
          state_nxt     = S_SCAN;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      in_tready_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      in_tready_r <= (state_nxt == S_IDLE);
    end
  end

  assign in_tready = in_tready_r;

endmodule

// ===== hw/rtl/sws_dp.sv =====
// Datapath of the sliding window sender: window state, acknowledge map, payload ring and
// output register.
module sws_dp import sws_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wen,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic [1:0]           item_command,
  input  logic [BYTE_W-1:0]    item_data_byte,
  input  logic [SEQ_W-1:0]     item_ack_number,
  input  logic                 item_ack_ok,
  input  sws_cmd_t             ctl,
  output sws_sts_t             sts,
  input  logic                 out_tready,
  output logic                 out_tvalid,
  output kind_t                out_kind,
  output logic [SEQ_W-1:0]     out_seq_number,
  output logic [BYTE_W-1:0]    out_payload,
  output logic [SEQ_W-1:0]     out_window_base,
  output logic                 out_accepted,
  output logic                 out_last
);

  function automatic logic [SLOT_W-1:0] slot_add(input logic [SLOT_W-1:0] s,
                                                 input logic [SLOT_W-1:0] off);
    logic [SUM_W-1:0] sum;
    sum = {1'b0, s} + {1'b0, off};
    if (sum >= SUM_W'(BUF_DEPTH)) begin
      sum = sum - SUM_W'(BUF_DEPTH);
    end
    return sum[SLOT_W-1:0];
  endfunction

  function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
    return (s == SLOT_W'(BUF_DEPTH - 1)) ? '0 : s + SLOT_W'(1);
  endfunction

  // Configuration registers.
  logic [WIN_W-1:0] win_r;
  logic [SEQ_W-1:0] msg_len_r;

  // Captured input item.
  logic [1:0]        item_cmd_r;
  logic [BYTE_W-1:0] item_byte_r;
  logic [SEQ_W-1:0]  item_ackn_r;
  logic              item_ok_r;

  // Window state.
  logic [SEQ_W-1:0]     base_r, base_nxt;
  logic [SEQ_W-1:0]     hack_r, hack_nxt;
  logic [SEQ_W-1:0]     load_r, load_nxt;
  logic [SLOT_W-1:0]    base_slot_r, base_slot_nxt;
  logic [SLOT_W-1:0]    load_slot_r, load_slot_nxt;
  logic [BUF_DEPTH-1:0] acked_r, acked_nxt;

  // Send round walker.
  logic [NLANE-1:0]  elig_r, elig_nxt;
  logic [SEQ_W-1:0]  scan_seq_r, scan_seq_nxt;
  logic [SLOT_W-1:0] scan_slot_r, scan_slot_nxt;
  logic [NLANE-1:0]  lane_elig;

  // Output register.
  logic              out_valid_r;
  kind_t             out_kind_r;
  logic [SEQ_W-1:0]  out_seq_r;
  logic [BYTE_W-1:0] out_pay_r;
  logic [SEQ_W-1:0]  out_base_r;
  logic              out_acc_r;
  logic              out_last_r;

  logic [SEQ_W-1:0]  ack_seq;
  logic [SEQ_W-1:0]  ack_off;
  logic [SLOT_W-1:0] ack_slot;
  logic              ack_valid;
  logic              load_ok;
  logic              out_free;
  logic [BYTE_W-1:0] ram_rdata;

  sws_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(BUF_DEPTH)
  ) u_payload_ram (
    .clk  (clk),
    .we   (ctl.do_load),
    .waddr(load_slot_r),
    .wdata(item_byte_r),
    .re   (ctl.ram_rd),
    .raddr(scan_slot_r),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (ctl.cap_item) begin
      item_cmd_r  <= item_command;
      item_byte_r <= item_data_byte;
      item_ackn_r <= item_ack_number;
      item_ok_r   <= item_ack_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r     <= WIN_RESET;
      msg_len_r <= '0;
    end else if (cfg_wen) begin
      if (cfg_idx == REG_WINDOW_SIZE) begin
        win_r <= cfg_wdata[WIN_W-1:0];
      end
      if (cfg_idx == REG_MESSAGE_LENGTH) begin
        msg_len_r <= cfg_wdata[SEQ_W-1:0];
      end
    end
  end

  assign load_ok = ((load_r - base_r) < SEQ_W'(BUF_DEPTH)) && (load_r < msg_len_r);

  assign ack_seq   = item_ackn_r - SEQ_W'(1);
  assign ack_off   = ack_seq - base_r;
  assign ack_slot  = slot_add(base_slot_r, ack_off[SLOT_W-1:0]);
  assign ack_valid = item_ok_r && (item_ackn_r != '0) && (ack_seq >= base_r) &&
                     (ack_off < SEQ_W'(BUF_DEPTH)) && (ack_seq < load_r);

  // Each lane of the window is judged on its own; the walker then emits them in order.
  always_comb begin
    logic [SEQ_W:0]    lane_seq;
    logic [SEQ_W:0]    win_lim;
    logic [SLOT_W-1:0] lane_slot;
    win_lim = {1'b0, hack_r} + (SEQ_W+1)'(win_r);
    for (int i = 0; i < NLANE; i++) begin
      lane_seq  = {1'b0, base_r} + (SEQ_W+1)'(i);
      lane_slot = slot_add(base_slot_r, SLOT_W'(i));
      lane_elig[i] = (WIN_W'(i) < win_r) && (lane_seq <= win_lim) &&
                     (lane_seq < {1'b0, msg_len_r}) && (lane_seq < {1'b0, load_r}) &&
                     !acked_r[lane_slot];
    end
  end

  always_comb begin
    base_nxt      = base_r;
    hack_nxt      = hack_r;
    load_nxt      = load_r;
    base_slot_nxt = base_slot_r;
    load_slot_nxt = load_slot_r;
    acked_nxt     = acked_r;
    elig_nxt      = elig_r;
    scan_seq_nxt  = scan_seq_r;
    scan_slot_nxt = scan_slot_r;
    if (ctl.do_load) begin
      load_nxt      = load_r + SEQ_W'(1);
      load_slot_nxt = slot_inc(load_slot_r);
    end
    if (ctl.ack_mark) begin
      acked_nxt[ack_slot] = 1'b1;
      if (item_ackn_r > hack_r) begin
        hack_nxt = item_ackn_r;
      end
    end
    if (ctl.adv_step) begin
      acked_nxt[base_slot_r] = 1'b0;
      base_nxt               = base_r + SEQ_W'(1);
      base_slot_nxt          = slot_inc(base_slot_r);
    end
    if (ctl.cap_elig) begin
      elig_nxt      = lane_elig;
      scan_seq_nxt  = base_r;
      scan_slot_nxt = base_slot_r;
    end else if (ctl.scan_step) begin
      elig_nxt      = elig_r >> 1;
      scan_seq_nxt  = scan_seq_r + SEQ_W'(1);
      scan_slot_nxt = slot_inc(scan_slot_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r      <= '0;
      hack_r      <= '0;
      load_r      <= '0;
      base_slot_r <= '0;
      load_slot_r <= '0;
      acked_r     <= '0;
      elig_r      <= '0;
    end else begin
      base_r      <= base_nxt;
      hack_r      <= hack_nxt;
      load_r      <= load_nxt;
      base_slot_r <= base_slot_nxt;
      load_slot_r <= load_slot_nxt;
      acked_r     <= acked_nxt;
      elig_r      <= elig_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scan_seq_r  <= scan_seq_nxt;
    scan_slot_r <= scan_slot_nxt;
  end

  assign out_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      out_kind_r <= ctl.emit_kind;
      out_base_r <= base_r;
      out_acc_r  <= ctl.emit_acc;
      out_last_r <= ctl.emit_last;
      case (ctl.emit_kind)
        KIND_DATA: begin
          out_seq_r <= scan_seq_r;
          out_pay_r <= ram_rdata;
        end
        KIND_TERM: begin
          out_seq_r <= TERM_SEQ;
          out_pay_r <= '0;
        end
        default: begin
          out_seq_r <= '0;
          out_pay_r <= '0;
        end
      endcase
    end
  end

  assign sts.cmd       = item_cmd_r;
  assign sts.load_ok   = load_ok;
  assign sts.ack_valid = ack_valid;
  assign sts.base_done = (base_r >= msg_len_r);
  assign sts.adv_more  = (base_r < msg_len_r) && acked_r[base_slot_r];
  assign sts.elig_any  = |elig_r;
  assign sts.elig_cur  = elig_r[0];
  assign sts.elig_rest = |elig_r[NLANE-1:1];
  assign sts.out_free  = out_free;

  assign out_tvalid      = out_valid_r;
  assign out_kind        = out_kind_r;
  assign out_seq_number  = out_seq_r;
  assign out_payload     = out_pay_r;
  assign out_window_base = out_base_r;
  assign out_accepted    = out_acc_r;
  assign out_last        = out_last_r;

  a_base_not_past_load: assert property (@(posedge clk) disable iff (!rst_n)
    base_r <= load_r)
    else $error("window base has passed the load count");

  a_ring_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (load_r - base_r) <= SEQ_W'(BUF_DEPTH))
    else $error("more bytes loaded than the ring holds");

  a_emit_into_free_reg: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.emit |-> out_free)
    else $error("result written over one not yet transferred");

  a_ack_marks_slot: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.ack_mark |=> acked_r[$past(ack_slot)])
    else $error("acknowledged slot not marked");

endmodule

// ===== bench/testbench.sv =====
// Self-checking testbench for the sliding window sender: directed and random item streams.
module testbench;
  import sws_pkg::*;

  // Command code with no meaning to the block; it must produce no result.
  localparam logic [1:0] CMD_NONE = 2'd3;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    kind_t             kind;
    logic [SEQ_W-1:0]  seq;
    logic [BYTE_W-1:0] payload;
    logic [SEQ_W-1:0]  base;
    logic              accepted;
    logic              is_last;
  } packet_t;

  class window_scoreboard;
    int unsigned win;
    int unsigned msg_len;
    int unsigned base;
    int unsigned top_ack;
    int unsigned loads;
    bit          acked[BUF_DEPTH];
    logic [7:0]  ring[BUF_DEPTH];
    packet_t     due_packets[$];
    int          errors;

    function new();
      win = 4;
      msg_len = 0;
      base = 0;
      top_ack = 0;
      loads = 0;
      errors = 0;
      foreach (acked[i]) acked[i] = 1'b0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
      if (idx == REG_WINDOW_SIZE) win = 32'(value[WIN_W-1:0]);
      else if (idx == REG_MESSAGE_LENGTH) msg_len = 32'(value);
    endfunction

    function void push(kind_t kind, int unsigned seq, logic [7:0] payload, bit acc,
                       bit is_last);
      packet_t p;
      p.kind = kind;
      p.seq = seq[SEQ_W-1:0];
      p.payload = payload;
      p.base = base[SEQ_W-1:0];
      p.accepted = acc;
      p.is_last = is_last;
      due_packets.insert(due_packets.size(), p);
    endfunction

    // Works out the packets that one accepted item causes and updates the window state.
    function void predict_packets(logic [1:0] cmd, logic [7:0] dbyte, logic [15:0] ackn,
                                  logic ok);
      int unsigned lanes;
      int unsigned seq;
      int          first;
      bit          acc;
      acc = 1'b0;
      case (cmd)
        CMD_LOAD: begin
          if (loads - base < BUF_DEPTH && loads < msg_len) begin
            ring[loads % BUF_DEPTH] = dbyte;
            loads++;
            acc = 1'b1;
          end
          push(KIND_LOAD, 0, 8'h00, acc, 1'b1);
        end
        CMD_SEND: begin
          if (base >= msg_len) begin
            push(KIND_TERM, 32'(TERM_SEQ), 8'h00, 1'b0, 1'b1);
          end else begin
            lanes = win;
            if (lanes > BUF_DEPTH) lanes = BUF_DEPTH;
            if (lanes > MAX_OUT) lanes = MAX_OUT;
            first = due_packets.size();
            for (int unsigned i = 0; i < lanes; i++) begin
              seq = base + i;
              if (seq <= top_ack + win && seq < msg_len && seq < loads &&
                  !acked[seq % BUF_DEPTH])
                push(KIND_DATA, seq, ring[seq % BUF_DEPTH], 1'b0, 1'b0);
            end
            if (due_packets.size() > first)
              due_packets[due_packets.size() - 1].is_last = 1'b1;
          end
        end
        CMD_ACK: begin
          if (ok && ackn != 0) begin
            seq = 32'(ackn) - 1;
            if (seq >= base && seq - base < BUF_DEPTH && seq < loads) begin
              acked[seq % BUF_DEPTH] = 1'b1;
              if (32'(ackn) > top_ack) top_ack = 32'(ackn);
              for (int steps = 0; steps < BUF_DEPTH; steps++) begin
                if (base >= msg_len || !acked[base % BUF_DEPTH]) break;
                acked[base % BUF_DEPTH] = 1'b0;
                base++;
              end
              acc = 1'b1;
            end
          end
          push(KIND_ACK, 0, 8'h00, acc, 1'b1);
        end
        default: ;
      endcase
    endfunction

    function void check_packet(packet_t got);
      packet_t want;
      if (due_packets.size() == 0) begin
        $error("unexpected packet: kind %0d seq %0d", got.kind, got.seq);
        errors++;
        return;
      end
      want = due_packets.pop_front();
      if (got.kind != want.kind) begin
        $error("kind: expected %0d, got %0d", want.kind, got.kind);
        errors++;
      end
      if (got.seq != want.seq) begin
        $error("seq_number: expected %0d, got %0d", want.seq, got.seq);
        errors++;
      end
      if (got.payload != want.payload) begin
        $error("payload: expected %0d, got %0d", want.payload, got.payload);
        errors++;
      end
      if (got.base != want.base) begin
        $error("window_base: expected %0d, got %0d", want.base, got.base);
        errors++;
      end
      if (got.accepted != want.accepted) begin
        $error("accepted: expected %0d, got %0d", want.accepted, got.accepted);
        errors++;
      end
      if (got.is_last != want.is_last) begin
        $error("last: expected %0d, got %0d", want.is_last, got.is_last);
        errors++;
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_wen = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [31:0]          in_tdata = '0;   // data_byte[7:0], ack_number[23:8], ack_ok[24]
  logic [1:0]           in_tuser = '0;   // command[1:0]
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [47:0]          out_tdata;       // seq_number[15:0], payload[23:16],
                                         // window_base[39:24], accepted[40]
  logic [1:0]           out_tuser;       // kind[1:0]
  logic                 out_tlast;

  int send_idle_pct = 17;
  int recv_idle_pct = 46;
  int hold_left = 0;
  bit hold_go = 1'b0;
  bit hold_used = 1'b0;
  window_scoreboard sb;

  sliding_window_sender_top dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #(12 * 400000);
    $display("FAIL");
    $finish;
  end

  // Receiver: random back-pressure, plus one long hold-off once it is requested.
  always @(posedge clk) begin
    if (hold_go && !hold_used) begin
      hold_used <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_packet({kind_t'(out_tuser), out_tdata[15:0], out_tdata[23:16],
                       out_tdata[39:24], out_tdata[40], out_tlast});
  end

  task automatic send_item(logic [1:0] cmd, logic [7:0] dbyte, logic [15:0] ackn, logic ok);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= cmd;
    in_tdata <= {7'd0, ok, ackn, dbyte};
    do @(posedge clk); while (!in_tready);
    sb.predict_packets(cmd, dbyte, ackn, ok);
  endtask

  // Lets every expected packet drain, then gives rounds with no output time to finish.
  task automatic settle();
    in_tvalid <= 1'b0;
    while (sb.due_packets.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_regs(logic [WIN_W-1:0] win, logic [CFG_W-1:0] len);
    cfg_wen <= 1'b1;
    cfg_idx <= REG_WINDOW_SIZE;
    cfg_wdata <= CFG_W'(win);
    @(posedge clk);
    sb.set_reg(REG_WINDOW_SIZE, CFG_W'(win));
    cfg_idx <= REG_MESSAGE_LENGTH;
    cfg_wdata <= len;
    @(posedge clk);
    sb.set_reg(REG_MESSAGE_LENGTH, len);
    cfg_wen <= 1'b0;
  endtask

  // Mostly loads, send rounds and plausible acknowledgements, with some noise.
  task automatic random_item();
    int         r;
    logic [1:0] cmd;
    logic [7:0] dbyte;
    logic [15:0] ackn;
    logic       ok;
    r = $urandom_range(0, 99);
    dbyte = 8'($urandom);
    ackn = 16'($urandom);
    ok = 1'($urandom);
    if (r < 35) begin
      cmd = CMD_LOAD;
    end else if (r < 55) begin
      cmd = CMD_SEND;
    end else if (r < 90) begin
      cmd = CMD_ACK;
      ok = ($urandom_range(0, 19) != 0);
      if (sb.loads > sb.base) begin
        if ($urandom_range(0, 1)) ackn = 16'(sb.base + 1);
        else ackn = 16'($urandom_range(sb.base, sb.loads - 1) + 1);
      end else begin
        ackn = 16'(sb.loads + $urandom_range(0, 1));
      end
    end else if (r < 96) begin
      cmd = CMD_ACK;
    end else begin
      cmd = CMD_NONE;
    end
    send_item(cmd, dbyte, ackn, ok);
  endtask

  initial begin
    logic [WIN_W-1:0] windows[6];
    logic [CFG_W-1:0] len;
    sb = new();
    windows = '{5'd1, 5'd0, 5'd16, 5'd31, 5'd7, 5'd16};
    windows[4] = 5'($urandom_range(2, 15));
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Empty message: terminate, refused load, ignored command, refused ack.
    write_regs(5'd4, 16'd0);
    send_item(CMD_SEND, 8'h00, 16'h0000, 1'b0);
    send_item(CMD_LOAD, 8'hFF, 16'hFFFF, 1'b1);
    send_item(CMD_NONE, 8'hFF, 16'hFFFF, 1'b1);
    send_item(CMD_ACK, 8'h00, 16'hFFFF, 1'b1);
    settle();

    // Fill the ring until a load is refused, send the full window, then bad and good acks.
    write_regs(5'd16, 16'd20);
    for (int i = 0; i < 17; i++)
      send_item(CMD_LOAD, (i == 0) ? 8'h00 : (i == 1) ? 8'hFF : 8'($urandom), 16'h0, 1'b0);
    send_item(CMD_SEND, 8'h00, 16'h0, 1'b0);
    send_item(CMD_ACK, 8'h00, 16'd0, 1'b1);
    send_item(CMD_ACK, 8'h00, 16'd2, 1'b0);
    send_item(CMD_ACK, 8'h00, 16'd3, 1'b1);
    send_item(CMD_ACK, 8'h00, 16'd1, 1'b1);
    send_item(CMD_ACK, 8'h00, 16'd1, 1'b1);
    send_item(CMD_ACK, 8'h00, 16'd18, 1'b1);
    send_item(CMD_SEND, 8'h00, 16'h0, 1'b0);

    for (int p = 0; p < 6; p++) begin
      if (p == 2) begin
        send_idle_pct = 46;
        recv_idle_pct = 17;
      end else if (p == 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      settle();
      len = (p == 5) ? 16'hFFFF : CFG_W'(sb.loads + $urandom_range(8, 40));
      write_regs(windows[p], len);
      // Long receiver hold-off so that the block fills up and stops taking items.
      if (p == 1) hold_go = 1'b1;
      repeat (65) random_item();
    end
    settle();

    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/sws_pkg.sv
hw/rtl/sws_ram.sv
hw/rtl/sws_ctrl.sv
hw/rtl/sws_dp.sv
hw/rtl/sliding_window_sender_top.sv
bench/testbench.sv
